### src/fpdf_pkg.sv
// ----------------------------------------------------------------------------
// fpdf_pkg
// Shared beat types, control groups and character codes of the fixed-point
// decimal formatter.
// ----------------------------------------------------------------------------
package fpdf_pkg;

   typedef struct packed {
      logic signed [31:0] number;
      logic [4:0]         frac_digits;
   } req_type;

   typedef struct packed {
      logic [7:0] ascii_char;
      logic       last_char;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic conv;
      logic shift;
   } bcd_ctl_type;

   typedef struct packed {
      logic load;
      logic step;
   } frac_ctl_type;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] MAX_NUMBER = 8'd9;

endpackage

### src/fpdf_bcd_conv.sv
// ----------------------------------------------------------------------------
// fpdf_bcd_conv
// Bit-serial binary to BCD converter (shift and add 3), then a digit shifter
// that presents the most significant digit.
// ----------------------------------------------------------------------------
module fpdf_bcd_conv #(
   parameter int INT_BITS   = 16,
   parameter int INT_DIGITS = 5
) (
   input  logic                  clock,
   input  fpdf_pkg::bcd_ctl_type ctl,
   input  logic [INT_BITS-1:0]   bin_value,
   output logic [3:0]            top_digit
);
   import fpdf_pkg::*;

   localparam int BCD_W = INT_DIGITS * 4;

   logic [INT_BITS-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]    bcd_ff, bcd_in;
   logic [BCD_W-1:0]    adj;

   always_comb begin
      for (int i = 0; i < INT_DIGITS; i++) begin
         adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                     : bcd_ff[i*4 +: 4];
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      priority if (ctl.load) begin
         bin_in = bin_value;
         bcd_in = '0;
      end else if (ctl.conv) begin
         bcd_in = {adj[BCD_W-2:0], bin_ff[INT_BITS-1]};
         bin_in = {bin_ff[INT_BITS-2:0], 1'b0};
      end else if (ctl.shift) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'b0000};
      end else begin
         bin_in = bin_ff;
         bcd_in = bcd_ff;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BCD_W-1 -: 4];

endmodule

### src/fpdf_frac_digit.sv
// ----------------------------------------------------------------------------
// fpdf_frac_digit
// Fraction digit generator: each step multiplies the fraction by ten, the
// carry-out nibble is the digit and the low bits stay as the new fraction.
// ----------------------------------------------------------------------------
module fpdf_frac_digit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  fpdf_pkg::frac_ctl_type ctl,
   input  logic [FRAC_BITS-1:0]   frac_value,
   output logic [3:0]             digit
);
   import fpdf_pkg::*;

   logic [FRAC_BITS-1:0] frac_ff, frac_in;
   logic [FRAC_BITS+3:0] prod;

   assign prod  = {1'b0, frac_ff, 3'b000} + {3'b000, frac_ff, 1'b0};
   assign digit = prod[FRAC_BITS+3:FRAC_BITS];

   always_comb begin
      frac_in = frac_ff;
      priority if (ctl.load) begin
         frac_in = frac_value;
      end else if (ctl.step) begin
         frac_in = prod[FRAC_BITS-1:0];
      end else begin
         frac_in = frac_ff;
      end
   end

   always_ff @(posedge clock) begin
      frac_ff <= frac_in;
   end

endmodule

### src/fixed_point_decimal_formatter_unit.sv
// ----------------------------------------------------------------------------
// fixed_point_decimal_formatter_unit
// Formats a signed fixed-point number as ASCII decimal, one character a beat.
//
//   channel  dir  payload                 handshake
//   req      in   number, frac_digits     req_valid / req_ready
//   rsp      out  ascii_char, last_char   rsp_valid / rsp_ready
//
// One number at a time: an accept step, serial BCD conversion of the 32-FRAC_BITS
// integer bits, a leading-zero skip, then the characters (at most 23 at default
// parameters), each one sent when the output slot is free.
// The conversion length is set by the one-bit-per-cycle BCD shifter.
// Reset is synchronous and clears the sequencer and the output valid.
// A stalled rsp holds the sequencer in its character states; req_ready is high only between numbers.
// ----------------------------------------------------------------------------
module fixed_point_decimal_formatter_unit #(
   parameter int FRAC_BITS     = 16,
   parameter int MAX_PRECISION = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fpdf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fpdf_pkg::rsp_type rsp_data
);
   import fpdf_pkg::*;

   localparam int INT_BITS   = 32 - FRAC_BITS;
   localparam int INT_DIGITS = (INT_BITS * 30103) / 100000 + 1;
   localparam int CNT_MAX    = (INT_BITS > MAX_PRECISION) ? INT_BITS : MAX_PRECISION;
   localparam int CNT_W      = $clog2(CNT_MAX + 1);
   localparam int PREC_W     = $clog2(MAX_PRECISION + 1);

   typedef enum logic [2:0] {
      IDLE, CONV, SKIP, SIGN, INTD, DOT, FRAC
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PREC_W-1:0] prec_ff, prec_in;
   logic              neg_ff, neg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              slot_free;
   logic              emit;
   logic [31:0]       raw;
   logic [31:0]       mag;
   logic [3:0]        int_digit;
   logic [3:0]        frac_digit;
   bcd_ctl_type       bcd_ctl;
   frac_ctl_type      frac_ctl;

   assign raw       = req_data.number;
   assign mag       = !raw[31]              ? raw :
                      (raw == 32'h8000_0000) ? 32'h7FFF_FFFF : (~raw + 32'd1);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == IDLE);

   fpdf_bcd_conv #(
      .INT_BITS   (INT_BITS),
      .INT_DIGITS (INT_DIGITS)
   ) u_bcd (
      .clock     (clock),
      .ctl       (bcd_ctl),
      .bin_value (mag[31:FRAC_BITS]),
      .top_digit (int_digit)
   );

   fpdf_frac_digit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_frac (
      .clock      (clock),
      .ctl        (frac_ctl),
      .frac_value (mag[FRAC_BITS-1:0]),
      .digit      (frac_digit)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      prec_in  = prec_ff;
      neg_in   = neg_ff;
      rsp_in   = rsp_ff;
      emit     = 1'b0;
      bcd_ctl  = '0;
      frac_ctl = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               bcd_ctl.load  = 1'b1;
               frac_ctl.load = 1'b1;
               neg_in        = raw[31];
               prec_in       = (req_data.frac_digits > 5'(MAX_PRECISION))
                               ? PREC_W'(MAX_PRECISION) : req_data.frac_digits[PREC_W-1:0];
               cnt_in        = CNT_W'(INT_BITS);
               state_in      = CONV;
            end
         end
         CONV: begin
            bcd_ctl.conv = 1'b1;
            cnt_in       = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               cnt_in   = CNT_W'(INT_DIGITS);
               state_in = SKIP;
            end
         end
         SKIP: begin
            if (int_digit == 4'd0 && cnt_ff > CNT_W'(1)) begin
               bcd_ctl.shift = 1'b1;
               cnt_in        = cnt_ff - CNT_W'(1);
            end else begin
               state_in = neg_ff ? SIGN : INTD;
            end
         end
         SIGN: begin
            if (slot_free) begin
               emit     = 1'b1;
               rsp_in   = '{ascii_char: CHAR_MINUS, last_char: 1'b0};
               state_in = INTD;
            end
         end
         INTD: begin
            if (slot_free) begin
               emit          = 1'b1;
               bcd_ctl.shift = 1'b1;
               rsp_in        = '{ascii_char: CHAR_ZERO + {4'b0000, int_digit},
                                 last_char: (cnt_ff == CNT_W'(1)) && (prec_ff == '0)};
               cnt_in        = cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = (prec_ff == '0) ? IDLE : DOT;
               end
            end
         end
         DOT: begin
            if (slot_free) begin
               emit     = 1'b1;
               rsp_in   = '{ascii_char: CHAR_POINT, last_char: 1'b0};
               cnt_in   = CNT_W'(prec_ff);
               state_in = FRAC;
            end
         end
         FRAC: begin
            if (slot_free) begin
               emit          = 1'b1;
               frac_ctl.step = 1'b1;
               rsp_in        = '{ascii_char: CHAR_ZERO + {4'b0000, frac_digit},
                                 last_char: (cnt_ff == CNT_W'(1))};
               cnt_in        = cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = IDLE;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff  <= cnt_in;
      prec_ff <= prec_in;
      neg_ff  <= neg_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // digit states never run with an exhausted count
   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == INTD || state_ff == FRAC || state_ff == CONV) |-> cnt_ff != '0)
      else $error("digit count exhausted in a digit state");

   a_int_dec: assert property (@(posedge clock) disable iff (reset)
      (emit && state_ff == INTD) |-> {4'b0000, int_digit} <= MAX_NUMBER)
      else $error("integer BCD digit out of range");

   a_frac_dec: assert property (@(posedge clock) disable iff (reset)
      (emit && state_ff == FRAC) |-> {4'b0000, frac_digit} <= MAX_NUMBER)
      else $error("fraction digit out of range");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (emit && rsp_in.last_char) |=> state_ff == IDLE)
      else $error("final beat without return to idle");

endmodule
